>>> hw/rtl/assert_macros.svh
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every clock edge while reset is released
`define GZ_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("gzip header stripper check failed");

// checked on every clock edge, reset included
`define GZ_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("gzip header stripper check failed");

`endif

>>> hw/rtl/gzhs_pkg.sv
package gzhs_pkg;

    localparam logic [7:0] MAGIC0         = 8'h1F;
    localparam logic [7:0] MAGIC1         = 8'h8B;
    localparam logic [7:0] METHOD_DEFLATE = 8'h08;

    localparam int FL_HCRC_BIT    = 1;
    localparam int FL_EXTRA_BIT   = 2;
    localparam int FL_NAME_BIT    = 3;
    localparam int FL_COMMENT_BIT = 4;

    localparam logic [3:0] FIXED_LAST = 4'd9;
    localparam logic [3:0] IDX_MAGIC0 = 4'd0;
    localparam logic [3:0] IDX_MAGIC1 = 4'd1;
    localparam logic [3:0] IDX_METHOD = 4'd2;
    localparam logic [3:0] IDX_FLAGS  = 4'd3;

    localparam logic [3:0] PH_FIXED    = 4'd0;
    localparam logic [3:0] PH_XLEN0    = 4'd1;
    localparam logic [3:0] PH_XLEN1    = 4'd2;
    localparam logic [3:0] PH_XDATA    = 4'd3;
    localparam logic [3:0] PH_NAME     = 4'd4;
    localparam logic [3:0] PH_COMMENT  = 4'd5;
    localparam logic [3:0] PH_HCRC0    = 4'd6;
    localparam logic [3:0] PH_HCRC1    = 4'd7;
    localparam logic [3:0] PH_BODY     = 4'd8;
    localparam logic [3:0] PH_BADMAGIC = 4'd9;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_BAD   = 2'd1;
    localparam logic [1:0] ST_TRUNC = 2'd2;
    localparam logic [1:0] ST_SHORT = 2'd3;

    typedef struct packed {
        logic in_body;   // byte of this request belongs to the body
        logic done;      // header complete after this byte
        logic bad;       // magic or method mismatch seen
    } t_hdr_info;

    function automatic logic [3:0] next_section(input logic [3:0] after,
                                                input logic [7:0] flags);
        logic [3:0] ph;
        ph = PH_BODY;
        if (after < PH_HCRC0 && flags[FL_HCRC_BIT]) ph = PH_HCRC0;
        if (after < PH_COMMENT && flags[FL_COMMENT_BIT]) ph = PH_COMMENT;
        if (after < PH_NAME && flags[FL_NAME_BIT]) ph = PH_NAME;
        if (after < PH_XLEN0 && flags[FL_EXTRA_BIT]) ph = PH_XLEN0;
        return ph;
    endfunction

endpackage

>>> hw/rtl/gzhs_if.sv
interface gzhs_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       final_byte;

    modport source (output valid, data_byte, final_byte, input ready);
    modport sink (input valid, data_byte, final_byte, output ready);
endinterface

interface gzhs_out_if;
    logic       valid;
    logic       ready;
    logic       body_valid;
    logic [7:0] body_byte;
    logic       header_done;
    logic [1:0] status;

    modport source (output valid, body_valid, body_byte, header_done, status,
                    input ready);
    modport sink (input valid, body_valid, body_byte, header_done, status,
                  output ready);
endinterface

>>> hw/rtl/gzhs_hdr_fsm.sv
module gzhs_hdr_fsm
    import gzhs_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_step,
    input  logic [7:0] i_data_byte,
    input  logic       i_final_byte,
    output t_hdr_info  o_info
);

    logic [3:0]  r_phase, n_phase;
    logic [3:0]  r_fixed_index, n_fixed_index;
    logic [7:0]  r_flags, n_flags;
    logic [15:0] r_extra, n_extra;
    logic        magic_bad;

    always_comb begin
        n_phase       = r_phase;
        n_fixed_index = r_fixed_index;
        n_flags       = r_flags;
        n_extra       = r_extra;
        magic_bad     = ((r_fixed_index == IDX_MAGIC0) && (i_data_byte != MAGIC0)) ||
                        ((r_fixed_index == IDX_MAGIC1) && (i_data_byte != MAGIC1)) ||
                        ((r_fixed_index == IDX_METHOD) && (i_data_byte != METHOD_DEFLATE));
        case (r_phase)
            PH_FIXED: begin
                if (magic_bad) begin
                    n_phase = PH_BADMAGIC;
                end else begin
                    if (r_fixed_index == IDX_FLAGS) n_flags = i_data_byte;
                    if (r_fixed_index >= FIXED_LAST) begin
                        n_phase = next_section(PH_FIXED, r_flags);
                    end else begin
                        n_fixed_index = r_fixed_index + 4'd1;
                    end
                end
            end
            PH_XLEN0: begin
                n_extra = {8'h00, i_data_byte};
                n_phase = PH_XLEN1;
            end
            PH_XLEN1: begin
                n_extra = {i_data_byte, r_extra[7:0]};
                n_phase = (n_extra != 16'd0) ? PH_XDATA : next_section(PH_XLEN1, r_flags);
            end
            PH_XDATA: begin
                n_extra = r_extra - 16'd1;
                if (n_extra == 16'd0) n_phase = next_section(PH_XDATA, r_flags);
            end
            PH_NAME, PH_COMMENT: begin
                if (i_data_byte == 8'h00) n_phase = next_section(r_phase, r_flags);
            end
            PH_HCRC0: begin
                n_phase = PH_HCRC1;
            end
            PH_HCRC1: begin
                n_phase = next_section(PH_HCRC1, r_flags);
            end
            PH_BODY: begin
                n_phase = PH_BODY;
            end
            default: begin
                n_phase = PH_BADMAGIC;
            end
        endcase
    end

    assign o_info.in_body = (r_phase == PH_BODY);
    assign o_info.done    = (n_phase == PH_BODY);
    assign o_info.bad     = (n_phase == PH_BADMAGIC);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_FIXED;
            r_fixed_index <= '0;
            r_flags       <= '0;
            r_extra       <= '0;
        end else if (i_step) begin
            if (i_final_byte) begin
                // member ends: restart for the next one whatever the outcome
                r_phase       <= PH_FIXED;
                r_fixed_index <= '0;
                r_flags       <= '0;
                r_extra       <= '0;
            end else begin
                r_phase       <= n_phase;
                r_fixed_index <= n_fixed_index;
                r_flags       <= n_flags;
                r_extra       <= n_extra;
            end
        end
    end

endmodule

>>> hw/rtl/gzhs_delay_line.sv
module gzhs_delay_line #(
    parameter int DEPTH = 8
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_shift,
    input  logic       i_clear,
    input  logic [7:0] i_byte,
    output logic       o_valid,
    output logic [7:0] o_byte
);

    localparam int FILL_W = $clog2(DEPTH + 1);

    logic [7:0]        r_line [DEPTH];
    logic [FILL_W-1:0] r_fill;

    // oldest byte leaves only once the trailer window is full
    assign o_valid = (r_fill >= FILL_W'(DEPTH));
    assign o_byte  = o_valid ? r_line[DEPTH-1] : 8'h00;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_line[0] <= i_byte;
            for (int i = 1; i < DEPTH; i++) begin
                r_line[i] <= r_line[i-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else if (i_clear) begin
            r_fill <= '0;
        end else if (i_shift && !o_valid) begin
            r_fill <= r_fill + FILL_W'(1);
        end
    end

endmodule

>>> hw/rtl/gzip_member_header_stripper_core.sv
// gzip member header stripper
// input channel i_in: one byte of a gzip member per request, final_byte set on
// the member's last byte. output channel o_out: exactly one result per input
// byte, in order. body_valid/body_byte carry compressed body bytes delayed by
// TRAILER_BYTES, so the trailer never appears. header_done is set once the
// header is consumed. status is nonzero only on the final byte's result:
// 1 bad magic or method, 2 header truncated, 3 body too short.
// the result of a byte is in the output register in the cycle after the byte is
// taken. throughput: one byte per cycle while the receiver does not stall; the
// header state machine and the delay line both update in the accepting cycle.
// i_in.ready is high while the output register is empty or is being drained in
// the same cycle; when the receiver stalls, the result holds and input waits.
// reset (synchronous, active low) empties the output register and returns the
// parser to the start of a member; delay line contents are not cleared, its
// fill count is. after every final byte the parser restarts for a new member.
`include "assert_macros.svh"

module gzip_member_header_stripper_core
    import gzhs_pkg::*;
#(
    parameter int TRAILER_BYTES = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    gzhs_in_if.sink           i_in,
    gzhs_out_if.source        o_out
);

    t_hdr_info  hdr_info;
    logic       in_fire;
    logic       dly_valid;
    logic [7:0] dly_byte;
    logic [1:0] n_status;

    logic       r_out_valid;
    logic       r_body_valid;
    logic [7:0] r_body_byte;
    logic       r_header_done;
    logic [1:0] r_status;

    assign i_in.ready = !r_out_valid || o_out.ready;
    assign in_fire    = i_in.valid && i_in.ready;

    gzhs_hdr_fsm u_hdr_fsm (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (in_fire),
        .i_data_byte  (i_in.data_byte),
        .i_final_byte (i_in.final_byte),
        .o_info       (hdr_info)
    );

    gzhs_delay_line #(
        .DEPTH (TRAILER_BYTES)
    ) u_delay_line (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_shift (in_fire && hdr_info.in_body),
        .i_clear (in_fire && i_in.final_byte),
        .i_byte  (i_in.data_byte),
        .o_valid (dly_valid),
        .o_byte  (dly_byte)
    );

    logic body_out;
    assign body_out = hdr_info.in_body && dly_valid;

    always_comb begin
        n_status = ST_OK;
        if (i_in.final_byte) begin
            if (hdr_info.bad) n_status = ST_BAD;
            else if (!hdr_info.done) n_status = ST_TRUNC;
            else if (!body_out) n_status = ST_SHORT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_fire) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_body_valid  <= body_out;
            r_body_byte   <= body_out ? dly_byte : 8'h00;
            r_header_done <= hdr_info.done;
            r_status      <= n_status;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.body_valid  = r_body_valid;
    assign o_out.body_byte   = r_body_byte;
    assign o_out.header_done = r_header_done;
    assign o_out.status      = r_status;

    `GZ_ASSERT(a_body_after_header, i_clk, i_rst_n, r_out_valid && r_body_valid |-> r_header_done)
    `GZ_ASSERT(a_short_no_body, i_clk, i_rst_n, r_out_valid && (r_status == ST_SHORT) |-> !r_body_valid)
    `GZ_ASSERT(a_error_no_header, i_clk, i_rst_n, r_out_valid && ((r_status == ST_BAD) || (r_status == ST_TRUNC)) |-> !r_header_done)
    `GZ_ASSERT_ALWAYS(a_reset_empties, i_clk, !i_rst_n |=> !r_out_valid)

endmodule
